/* hdl/x86_partial_register_access_assert.svh */
// Assertion macros for the x86 partial register access block.
// Used by the checker module; no other dependencies.
`ifndef X86_PARTIAL_REGISTER_ACCESS_ASSERT_SVH
`define X86_PARTIAL_REGISTER_ACCESS_ASSERT_SVH

// Clocked assertion, disabled while reset is asserted
`define XPRA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Overlapping implication built on the macro above
`define XPRA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	`XPRA_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)

`endif

/* hdl/xpra_pkg.sv */
// Shared types, register numbers and decode function for the x86 register block.
// No dependencies; imported by the top level, the RAM wrapper users and the checker.
`timescale 1ns / 1ps
`default_nettype none

package xpra_pkg;

	// Register store geometry
	localparam int REG_SLOTS = 16;
	localparam int SLOT_W    = $clog2(REG_SLOTS);
	localparam int DATA_W    = 32;
	localparam int INDEX_W   = 8;

	// Access status
	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_UNSUPPORTED = 2'd1,
		ST_INVALID     = 2'd2
	} status_t;

	// Register view
	typedef enum logic [1:0] {
		VIEW_LO   = 2'd0,
		VIEW_HI   = 2'd1,
		VIEW_WORD = 2'd2,
		VIEW_FULL = 2'd3
	} view_t;

	// Action flag
	localparam logic ACT_READ  = 1'b0;
	localparam logic ACT_WRITE = 1'b1;

	// CodeView register numbers
	localparam logic [INDEX_W-1:0] IDX_LO_FIRST    = 8'd1;
	localparam logic [INDEX_W-1:0] IDX_LO_LAST     = 8'd4;
	localparam logic [INDEX_W-1:0] IDX_HI_FIRST    = 8'd5;
	localparam logic [INDEX_W-1:0] IDX_HI_LAST     = 8'd8;
	localparam logic [INDEX_W-1:0] IDX_WORD_FIRST  = 8'd9;
	localparam logic [INDEX_W-1:0] IDX_WORD_LAST   = 8'd16;
	localparam logic [INDEX_W-1:0] IDX_DWORD_FIRST = 8'd17;
	localparam logic [INDEX_W-1:0] IDX_DWORD_LAST  = 8'd24;
	localparam logic [INDEX_W-1:0] IDX_SEG_FIRST   = 8'd25;
	localparam logic [INDEX_W-1:0] IDX_SEG_LAST    = 8'd30;
	localparam logic [INDEX_W-1:0] IDX_IP          = 8'd31;
	localparam logic [INDEX_W-1:0] IDX_FLAGS       = 8'd32;
	localparam logic [INDEX_W-1:0] IDX_EIP         = 8'd33;
	localparam logic [INDEX_W-1:0] IDX_EFLAGS      = 8'd34;
	localparam logic [INDEX_W-1:0] IDX_CR_FIRST    = 8'd80;
	localparam logic [INDEX_W-1:0] IDX_CR_LAST     = 8'd84;
	localparam logic [INDEX_W-1:0] IDX_DR_FIRST    = 8'd90;
	localparam logic [INDEX_W-1:0] IDX_DR_LAST     = 8'd97;

	// Store slots
	localparam logic [SLOT_W-1:0] SLOT_SEG_BASE = 4'd8;
	localparam logic [SLOT_W-1:0] SLOT_EIP      = 4'd14;
	localparam logic [SLOT_W-1:0] SLOT_EFLAGS   = 4'd15;

	// Merge masks: bits kept from the old value
	localparam logic [DATA_W-1:0] KEEP_LO   = 32'hFFFF_FF00;
	localparam logic [DATA_W-1:0] KEEP_HI   = 32'hFFFF_00FF;
	localparam logic [DATA_W-1:0] KEEP_WORD = 32'hFFFF_0000;

	typedef struct packed {
		status_t             status;
		logic [SLOT_W-1:0]   slot;
		view_t               view;
	} dec_t;

	// Register number to slot, view and status
	function automatic dec_t decode_index(input logic [INDEX_W-1:0] idx);
		dec_t d;
		d.status = ST_OK;
		d.slot   = '0;
		d.view   = VIEW_FULL;
		unique case (idx) inside
			[IDX_LO_FIRST:IDX_LO_LAST]: begin
				d.slot = SLOT_W'(idx - IDX_LO_FIRST);
				d.view = VIEW_LO;
			end
			[IDX_HI_FIRST:IDX_HI_LAST]: begin
				d.slot = SLOT_W'(idx - IDX_HI_FIRST);
				d.view = VIEW_HI;
			end
			[IDX_WORD_FIRST:IDX_WORD_LAST]: begin
				d.slot = SLOT_W'(idx - IDX_WORD_FIRST);
				d.view = VIEW_WORD;
			end
			[IDX_DWORD_FIRST:IDX_DWORD_LAST]: begin
				d.slot = SLOT_W'(idx - IDX_DWORD_FIRST);
				d.view = VIEW_FULL;
			end
			[IDX_SEG_FIRST:IDX_SEG_LAST]: begin
				d.slot = SLOT_SEG_BASE + SLOT_W'(idx - IDX_SEG_FIRST);
				d.view = VIEW_FULL;
			end
			IDX_IP: begin
				d.slot = SLOT_EIP;
				d.view = VIEW_WORD;
			end
			IDX_FLAGS: begin
				d.slot = SLOT_EFLAGS;
				d.view = VIEW_WORD;
			end
			IDX_EIP: begin
				d.slot = SLOT_EIP;
				d.view = VIEW_FULL;
			end
			IDX_EFLAGS: begin
				d.slot = SLOT_EFLAGS;
				d.view = VIEW_FULL;
			end
			[IDX_CR_FIRST:IDX_CR_LAST], [IDX_DR_FIRST:IDX_DR_LAST]: begin
				d.status = ST_UNSUPPORTED;
			end
			default: begin
				d.status = ST_INVALID;
			end
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

/* hdl/x86_partial_register_access.sv */
// Channel   | Dir | tdata (low bit up)             | tuser
// s_axis    | in  | reg_index[7:0], write_value    | action (1 = write)
// m_axis    | out | read_value[31:0]               | status[1:0]
//
// One word per cycle sustained while m_axis is not back-pressured. An accepted
// word reads the store RAM at once; the merge stage then merges and writes back,
// and the result lands in the output register. The RAM read data is registered; a
// write followed directly by an access to the same slot is forwarded.
// Reset clears the slot valid bits, so every register reads as zero; no sweep.
// Back-pressure on m_axis holds the merge stage, which then holds s_axis.
// Depends on xpra_pkg and xpra_ram.
`timescale 1ns / 1ps
`default_nettype none

module x86_partial_register_access (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [39:0] s_axis_tdata,  // reg_index[7:0], write_value[39:8]
	input  wire logic        s_axis_tuser,  // action
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,  // read_value
	output logic [1:0]       m_axis_tuser   // status
);

	import xpra_pkg::*;

	logic               accept;
	logic               advance;
	dec_t               dec_in;
	logic [DATA_W-1:0]  ram_rdata;
	logic               ram_we;
	logic [DATA_W-1:0]  cur_value;
	logic [DATA_W-1:0]  nxt_value;
	logic [DATA_W-1:0]  view_value;
	logic [DATA_W-1:0]  result_value;

	// merge stage
	logic               valid_s1;
	logic               write_s1;
	status_t            status_s1;
	logic [SLOT_W-1:0]  slot_s1;
	view_t              view_s1;
	logic [DATA_W-1:0]  wdata_s1;

	// slot valid bits and write forwarding
	logic [REG_SLOTS-1:0] present_q;
	logic                 fwd_valid_q;
	logic [SLOT_W-1:0]    fwd_slot_q;
	logic [DATA_W-1:0]    fwd_data_q;

	// output register
	logic               out_valid_q;
	logic [DATA_W-1:0]  out_data_q;
	status_t            out_status_q;

	// handshakes
	assign advance       = valid_s1 & (~out_valid_q | m_axis_tready);
	assign s_axis_tready = ~valid_s1 | advance;
	assign accept        = s_axis_tvalid & s_axis_tready;
	assign dec_in        = decode_index(s_axis_tdata[INDEX_W-1:0]);

	xpra_ram #(
		.WIDTH (DATA_W),
		.DEPTH (REG_SLOTS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_s1),
		.wdata (nxt_value),
		.re    (accept),
		.raddr (dec_in.slot),
		.rdata (ram_rdata)
	);

	// current register value: last write, RAM, or reset zero
	always_comb begin
		if (fwd_valid_q && fwd_slot_q == slot_s1) begin
			cur_value = fwd_data_q;
		end else if (present_q[slot_s1]) begin
			cur_value = ram_rdata;
		end else begin
			cur_value = '0;
		end
	end

	// view slice and write merge
	always_comb begin
		case (view_s1)
			VIEW_LO: begin
				view_value = {24'd0, cur_value[7:0]};
				nxt_value  = (cur_value & KEEP_LO) | {24'd0, wdata_s1[7:0]};
			end
			VIEW_HI: begin
				view_value = {24'd0, cur_value[15:8]};
				nxt_value  = (cur_value & KEEP_HI) | {16'd0, wdata_s1[7:0], 8'd0};
			end
			VIEW_WORD: begin
				view_value = {16'd0, cur_value[15:0]};
				nxt_value  = (cur_value & KEEP_WORD) | {16'd0, wdata_s1[15:0]};
			end
			default: begin
				view_value = cur_value;
				nxt_value  = wdata_s1;
			end
		endcase
	end

	assign ram_we       = advance & (write_s1 == ACT_WRITE) & (status_s1 == ST_OK);
	assign result_value = (write_s1 == ACT_READ && status_s1 == ST_OK) ? view_value : '0;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			present_q   <= '0;
			fwd_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (ram_we) begin
				present_q[slot_s1] <= 1'b1;
				fwd_valid_q        <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			write_s1  <= s_axis_tuser;
			status_s1 <= dec_in.status;
			slot_s1   <= dec_in.slot;
			view_s1   <= dec_in.view;
			wdata_s1  <= s_axis_tdata[INDEX_W +: DATA_W];
		end
		if (ram_we) begin
			fwd_slot_q <= slot_s1;
			fwd_data_q <= nxt_value;
		end
		if (advance) begin
			out_data_q   <= result_value;
			out_status_q <= status_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_status_q;

endmodule

`default_nettype wire

/* hdl/xpra_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module xpra_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* hdl/xpra_checker.sv */
// Port-level checker for the x86 partial register access block, bound to the top.
// Depends on xpra_pkg and x86_partial_register_access_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "x86_partial_register_access_assert.svh"

module xpra_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic [39:0] s_axis_tdata,
	input wire logic        s_axis_tuser,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [31:0] m_axis_tdata,
	input wire logic [1:0]  m_axis_tuser
);

	import xpra_pkg::*;

	logic unused_in;
	assign unused_in = s_axis_tvalid ^ s_axis_tuser ^ (^s_axis_tdata);

	// a stalled result word holds
	`XPRA_ASSERT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result word dropped or changed while stalled")

	// input stalls only behind a stalled output
	`XPRA_ASSERT_IMPL(a_stall_src, clk, arst_n, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled without output back-pressure")

	// status is one of the three defined codes
	`XPRA_ASSERT_IMPL(a_status_code, clk, arst_n, m_axis_tvalid, m_axis_tuser == ST_OK || m_axis_tuser == ST_UNSUPPORTED || m_axis_tuser == ST_INVALID, "undefined status code")

	// errors always return zero data
	`XPRA_ASSERT_IMPL(a_err_zero, clk, arst_n, m_axis_tvalid && m_axis_tdata != '0, m_axis_tuser == ST_OK, "nonzero data with error status")

endmodule

bind x86_partial_register_access xpra_checker u_xpra_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

/* tb/sv/x86_partial_register_access_test.sv */
// Testbench for the x86 partial register access block: directed view and error
// cases, then random accesses under random gaps and back-pressure.
// Depends on xpra_pkg and the x86_partial_register_access top level.
`timescale 1ns / 1ps

module x86_partial_register_access_test;
	import xpra_pkg::*;

	// Register numbers outside every listed range
	localparam logic [INDEX_W-1:0] IDX_ZERO = 8'd0;
	localparam logic [INDEX_W-1:0] IDX_TOP  = 8'd255;
	localparam int RANDOM_WORDS = 1800;
	localparam int IDLE_LIMIT   = 2000;

	typedef struct {
		status_t           st;
		logic [SLOT_W-1:0] slot;
		view_t             view;
	} view_sel_t;

	typedef struct {
		logic [DATA_W-1:0] read_value;
		status_t           status;
	} access_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [39:0]       s_axis_tdata = '0;  // reg_index[7:0], write_value[39:8]
	logic              s_axis_tuser = 1'b0;  // action
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [31:0]       m_axis_tdata;  // read_value
	logic [1:0]        m_axis_tuser;  // status

	// Shadow register set and expected results in order
	logic [DATA_W-1:0] shadow_regs [REG_SLOTS];
	access_result_t    pending_results [$];

	bit no_idle = 1'b0;
	int mismatches = 0;
	int results_seen = 0;
	int reads_sent = 0;
	int writes_sent = 0;
	int unsup_sent = 0;
	int invalid_sent = 0;
	int idle_cycles = 0;
	int ready_hold = 0;

	x86_partial_register_access dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Gap length: mostly none or short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Register number to slot and view
	function automatic view_sel_t locate_view(input logic [INDEX_W-1:0] idx);
		view_sel_t sel;
		logic [INDEX_W-1:0] off;
		sel.st   = ST_OK;
		sel.slot = '0;
		sel.view = VIEW_FULL;
		off      = '0;
		if (idx >= IDX_LO_FIRST && idx <= IDX_LO_LAST) begin
			off      = idx - IDX_LO_FIRST;
			sel.view = VIEW_LO;
		end else if (idx >= IDX_HI_FIRST && idx <= IDX_HI_LAST) begin
			off      = idx - IDX_HI_FIRST;
			sel.view = VIEW_HI;
		end else if (idx >= IDX_WORD_FIRST && idx <= IDX_WORD_LAST) begin
			off      = idx - IDX_WORD_FIRST;
			sel.view = VIEW_WORD;
		end else if (idx >= IDX_DWORD_FIRST && idx <= IDX_DWORD_LAST) begin
			off = idx - IDX_DWORD_FIRST;
		end else if (idx >= IDX_SEG_FIRST && idx <= IDX_SEG_LAST) begin
			off = idx - IDX_SEG_FIRST + INDEX_W'(SLOT_SEG_BASE);
		end else if (idx == IDX_IP || idx == IDX_EIP) begin
			off      = INDEX_W'(SLOT_EIP);
			sel.view = (idx == IDX_IP) ? VIEW_WORD : VIEW_FULL;
		end else if (idx == IDX_FLAGS || idx == IDX_EFLAGS) begin
			off      = INDEX_W'(SLOT_EFLAGS);
			sel.view = (idx == IDX_FLAGS) ? VIEW_WORD : VIEW_FULL;
		end else if ((idx >= IDX_CR_FIRST && idx <= IDX_CR_LAST) ||
				(idx >= IDX_DR_FIRST && idx <= IDX_DR_LAST)) begin
			sel.st = ST_UNSUPPORTED;
		end else begin
			sel.st = ST_INVALID;
		end
		sel.slot = off[SLOT_W-1:0];
		return sel;
	endfunction

	// Apply one access to the shadow set and return the expected result
	function automatic access_result_t model_access(input logic act,
			input logic [INDEX_W-1:0] idx, input logic [DATA_W-1:0] val);
		view_sel_t sel;
		access_result_t res;
		logic [DATA_W-1:0] cur;
		sel            = locate_view(idx);
		res.read_value = '0;
		res.status     = sel.st;
		if (sel.st == ST_OK) begin
			cur = shadow_regs[sel.slot];
			if (act == ACT_READ) begin
				case (sel.view)
					VIEW_LO:   res.read_value = {24'd0, cur[7:0]};
					VIEW_HI:   res.read_value = {24'd0, cur[15:8]};
					VIEW_WORD: res.read_value = {16'd0, cur[15:0]};
					default:   res.read_value = cur;
				endcase
			end else begin
				case (sel.view)
					VIEW_LO:   shadow_regs[sel.slot] = {cur[31:8], val[7:0]};
					VIEW_HI:   shadow_regs[sel.slot] = {cur[31:16], val[7:0], cur[7:0]};
					VIEW_WORD: shadow_regs[sel.slot] = {cur[31:16], val[15:0]};
					default:   shadow_regs[sel.slot] = val;
				endcase
			end
		end
		return res;
	endfunction

	// Send one word, wait for acceptance, then record its expected result
	task automatic send_access(input logic act, input logic [INDEX_W-1:0] idx,
			input logic [DATA_W-1:0] val);
		int gap;
		access_result_t res;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= 40'({$urandom(), $urandom()});
			s_axis_tuser  <= 1'($urandom_range(0, 1));
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {val, idx};
		s_axis_tuser  <= act;
		do
			@(posedge clk);
		while (!s_axis_tready);
		res = model_access(act, idx, val);
		pending_results.push_back(res);
		if (res.status == ST_UNSUPPORTED)
			unsup_sent++;
		else if (res.status == ST_INVALID)
			invalid_sent++;
		if (act == ACT_WRITE)
			writes_sent++;
		else
			reads_sent++;
	endtask

	// Random register value with the extremes mixed in
	function automatic logic [DATA_W-1:0] pick_word();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return $urandom();
	endfunction

	// Random register number, mostly valid views
	function automatic logic [INDEX_W-1:0] pick_index();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return INDEX_W'($urandom_range(IDX_LO_FIRST, IDX_EFLAGS));
		if (r < 80)
			return ($urandom_range(0, 1) != 0) ?
				INDEX_W'($urandom_range(IDX_CR_FIRST, IDX_CR_LAST)) :
				INDEX_W'($urandom_range(IDX_DR_FIRST, IDX_DR_LAST));
		return INDEX_W'($urandom_range(0, 255));
	endfunction

	// Registers read back as zero after reset
	task automatic test_reset_state();
		send_access(ACT_READ, IDX_DWORD_FIRST, '1);
		send_access(ACT_READ, IDX_EFLAGS, '0);
	endtask

	// Byte, high byte, word and dword merges
	task automatic test_partial_views();
		send_access(ACT_WRITE, IDX_DWORD_FIRST, 32'h1234_5678);
		send_access(ACT_WRITE, IDX_LO_FIRST, 32'hFFFF_FFAB);
		send_access(ACT_WRITE, IDX_HI_FIRST, 32'hFFFF_FFCD);
		send_access(ACT_READ, IDX_LO_FIRST, '0);
		send_access(ACT_READ, IDX_HI_FIRST, '0);
		send_access(ACT_READ, IDX_WORD_FIRST, '0);
		send_access(ACT_WRITE, IDX_WORD_FIRST, 32'hFFFF_0000);
		send_access(ACT_READ, IDX_DWORD_FIRST, '0);
		send_access(ACT_WRITE, IDX_DWORD_LAST, '1);
		send_access(ACT_WRITE, IDX_WORD_LAST, '0);
		send_access(ACT_READ, IDX_DWORD_LAST, '0);
	endtask

	// IP, FLAGS and segment views
	task automatic test_special_views();
		send_access(ACT_WRITE, IDX_EIP, '1);
		send_access(ACT_WRITE, IDX_IP, 32'h0001_0002);
		send_access(ACT_READ, IDX_EIP, '0);
		send_access(ACT_WRITE, IDX_FLAGS, '1);
		send_access(ACT_READ, IDX_EFLAGS, '0);
		send_access(ACT_WRITE, IDX_SEG_LAST, '1);
		send_access(ACT_READ, IDX_SEG_LAST, '0);
	endtask

	// Control/debug and unknown numbers change nothing
	task automatic test_error_codes();
		send_access(ACT_WRITE, IDX_CR_FIRST, '1);
		send_access(ACT_READ, IDX_DR_LAST, '0);
		send_access(ACT_WRITE, IDX_ZERO, '1);
		send_access(ACT_READ, IDX_TOP, '0);
		send_access(ACT_READ, IDX_DWORD_FIRST, '0);
	endtask

	// Random mix, with one stretch at full rate on both sides
	task automatic test_random_access();
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			no_idle = (i >= 600 && i < 800);
			send_access(1'($urandom_range(0, 1)), pick_index(), pick_word());
		end
		no_idle = 1'b0;
	endtask

	// Result checker
	always @(posedge clk) begin : result_check
		access_result_t exp_res;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("unexpected result: read_value %h status %0d", m_axis_tdata,
					m_axis_tuser);
				mismatches++;
			end else begin
				exp_res = pending_results.pop_front();
				if (m_axis_tdata !== exp_res.read_value) begin
					$error("read_value mismatch: expected %h, actual %h",
						exp_res.read_value, m_axis_tdata);
					mismatches++;
				end
				if (m_axis_tuser !== exp_res.status) begin
					$error("status mismatch: expected %0d, actual %0d",
						exp_res.status, m_axis_tuser);
					mismatches++;
				end
			end
		end
	end

	// Random back-pressure on the result side
	always @(posedge clk) begin : ready_gen
		int stall;
		if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
		end else if (m_axis_tready) begin
			stall = pick_gap();
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				ready_hold    <= stall - 1;
			end
		end else begin
			m_axis_tready <= 1'b1;
			ready_hold    <= $urandom_range(0, 10);
		end
	end

	// Watchdog on cycles with no handshake
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout with %0d results outstanding", pending_results.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < REG_SLOTS; i++)
			shadow_regs[i] = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		test_reset_state();
		test_partial_views();
		test_special_views();
		test_error_codes();
		test_random_access();
		s_axis_tvalid <= 1'b0;

		// Drain, then a few more cycles for any stray word
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Sent %0d reads and %0d writes; %0d control/debug, %0d invalid numbers.",
			reads_sent, writes_sent, unsup_sent, invalid_sent);
		$display("Compared %0d results, %0d mismatches.", results_seen, mismatches);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+hdl
hdl/xpra_pkg.sv
hdl/xpra_ram.sv
hdl/x86_partial_register_access.sv
hdl/xpra_checker.sv
tb/sv/x86_partial_register_access_test.sv
